FILE: hdl/rzs_pkg.sv
// Package for the rolling z-score signal block: sizes, register indexes
// and the sequencer state type. No dependencies.
`default_nettype none

package rzs_pkg;

	localparam int SYMBOL_SLOTS  = 4;
	localparam int WINDOW_LENGTH = 64;
	localparam int PRICE_BITS    = 24;

	localparam int SLOT_W  = $clog2(SYMBOL_SLOTS);
	localparam int HEAD_W  = $clog2(WINDOW_LENGTH);
	localparam int CNT_W   = $clog2(WINDOW_LENGTH + 1);
	localparam int ADDR_W  = $clog2(SYMBOL_SLOTS * WINDOW_LENGTH);
	localparam int DEPTH   = SYMBOL_SLOTS * WINDOW_LENGTH;

	// doubled mid, window sums and the exact variance terms
	localparam int MID_W   = PRICE_BITS + 1;
	localparam int SUM_W   = MID_W + HEAD_W;
	localparam int SQR_W   = 2 * MID_W;
	localparam int SQ_W    = 2 * MID_W + HEAD_W;
	localparam int VAR_W   = 2 * SUM_W;
	localparam int D4_W    = VAR_W + 2;

	localparam int RATIO_W = 8;
	localparam int THR_W   = VAR_W + RATIO_W;
	localparam int QTY_W   = 8;
	localparam int POS_W   = 8;
	localparam int POS_LIMIT = 127;

	localparam logic REG_ENTRY = 1'b0;
	localparam logic REG_EXIT  = 1'b1;

	localparam logic [RATIO_W-1:0] ENTRY_RESET = 8'd16;
	localparam logic [RATIO_W-1:0] EXIT_RESET  = 8'd1;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_FILL = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_SQUARE,
		ST_VARIANCE,
		ST_PRODUCT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: hdl/rolling_zscore_signal.sv
// Rolling z-score mean-reversion signal, top level. Uses rzs_pkg.
// Holds the ring of doubled mids in a synchronous RAM; per-slot sums in flops.
//
// channel  direction  handshake            payload
// in       input      in_valid / in_stall   operation, symbol_slot, bid/ask, fill_*
// out      output     out_valid / out_stall order_valid, order_side, order_price, order_slot
// cfg      input      cfg_write            cfg_index, cfg_data
//
// One word in flight: a full-window tick goes from accept to the next accept
// through RAM read, sum update, square update, variance, products and compare;
// a fill ends after the read step, a tick still filling the window after the square update.
// The result sits in an output register; a stalled output holds the sequencer
// in its final state. Reset clears sums, counts, heads, positions and ratios;
// the ring RAM needs no clearing.
`default_nettype none

module rolling_zscore_signal (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output      logic                            in_stall,
	input  wire logic                            operation,
	input  wire logic [rzs_pkg::SLOT_W-1:0]      symbol_slot,
	input  wire logic [rzs_pkg::PRICE_BITS-1:0]  bid_price,
	input  wire logic [rzs_pkg::PRICE_BITS-1:0]  ask_price,
	input  wire logic                            fill_side,
	input  wire logic [rzs_pkg::QTY_W-1:0]       fill_quantity,
	output      logic                            out_valid,
	input  wire logic                            out_stall,
	output      logic                            order_valid,
	output      logic                            order_side,
	output      logic [rzs_pkg::PRICE_BITS-1:0]  order_price,
	output      logic [rzs_pkg::SLOT_W-1:0]      order_slot,
	input  wire logic                            cfg_write,
	input  wire logic                            cfg_index,
	input  wire logic [rzs_pkg::RATIO_W-1:0]     cfg_data
);
	import rzs_pkg::*;

	state_t state_q, state_next;

	// per-slot state
	logic        [SUM_W-1:0]  sum_q  [SYMBOL_SLOTS];
	logic        [SQ_W-1:0]   sq_q   [SYMBOL_SLOTS];
	logic        [CNT_W-1:0]  cnt_q  [SYMBOL_SLOTS];
	logic        [HEAD_W-1:0] head_q [SYMBOL_SLOTS];
	logic signed [POS_W-1:0]  pos_q  [SYMBOL_SLOTS];

	logic [RATIO_W-1:0] entry_q, exit_q;

	// ring of doubled mids
	logic [MID_W-1:0]  ring_mem [DEPTH];
	logic [MID_W-1:0]  old_q;
	logic [ADDR_W-1:0] rd_addr;

	// captured word
	logic                  op_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [PRICE_BITS-1:0] bid_q, ask_q;
	logic [MID_W-1:0]      mid_q;
	logic                  side_q;
	logic [QTY_W-1:0]      qty_q;
	logic [ADDR_W-1:0]     addr_q;

	// datapath registers
	logic                  eval_q;
	logic [SUM_W-1:0]      nsum_q;
	logic [SQR_W-1:0]      mm_q, oo_q;
	logic [SQ_W-1:0]       nsq_q;
	logic [VAR_W-1:0]      var_q;
	logic [SUM_W-1:0]      dv_q;
	logic                  above_q;
	logic [VAR_W-1:0]      d2_q;
	logic [THR_W-1:0]      thr_q;

	logic in_accept, out_free, load_out;
	logic full_now, eval_now;
	logic signed [POS_W+1:0] pos_sum;
	logic signed [POS_W-1:0] pos_new;
	logic signed [POS_W-1:0] pos_cur;
	logic [SUM_W-1:0] wm;
	logic [D4_W-1:0]  d4;
	logic emit, sell;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid || !out_stall;
	assign rd_addr   = ADDR_W'(symbol_slot) * ADDR_W'(WINDOW_LENGTH)
		+ ADDR_W'(head_q[symbol_slot]);

	// ---------------- sequencer ----------------
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE:     if (in_valid) state_next = ST_READ;
			ST_READ:     state_next = (op_q == OP_FILL) ? ST_DONE : ST_SQUARE;
			ST_SQUARE:   state_next = eval_q ? ST_VARIANCE : ST_DONE;
			ST_VARIANCE: state_next = ST_PRODUCT;
			ST_PRODUCT:  state_next = ST_DONE;
			ST_DONE:     if (out_free) state_next = ST_IDLE;
			default:     state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall = (state_q != ST_IDLE);
		load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENTRY_RESET;
			exit_q  <= EXIT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_ENTRY: entry_q <= cfg_data;
				REG_EXIT:  exit_q  <= cfg_data;
				default:   ;
			endcase
		end
	end

	// ---------------- ring RAM ----------------
	always_ff @(posedge clk) begin
		if (state_q == ST_READ && op_q == OP_TICK) begin
			ring_mem[addr_q] <= mid_q;
		end
		if (in_accept) begin
			old_q <= ring_mem[rd_addr];
		end
	end

	// ---------------- capture ----------------
	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q   <= operation;
			slot_q <= symbol_slot;
			bid_q  <= bid_price;
			ask_q  <= ask_price;
			mid_q  <= MID_W'(bid_price) + MID_W'(ask_price);
			side_q <= fill_side;
			qty_q  <= fill_quantity;
			addr_q <= rd_addr;
		end
	end

	// ---------------- read stage: sum, squares, head, count ----------------
	assign full_now = (cnt_q[slot_q] == CNT_W'(WINDOW_LENGTH));
	assign eval_now = full_now || (cnt_q[slot_q] + CNT_W'(1) == CNT_W'(WINDOW_LENGTH));

	always_comb begin
		pos_cur = pos_q[slot_q];
		pos_sum = side_q ? (POS_W+2)'(pos_cur) - $signed({2'b00, qty_q})
			: (POS_W+2)'(pos_cur) + $signed({2'b00, qty_q});
		if (pos_sum > (POS_W+2)'(POS_LIMIT)) begin
			pos_new = POS_W'(POS_LIMIT);
		end else if (pos_sum < -(POS_W+2)'(POS_LIMIT)) begin
			pos_new = -POS_W'(POS_LIMIT);
		end else begin
			pos_new = pos_sum[POS_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			eval_q <= (op_q == OP_TICK) && eval_now;
			nsum_q <= sum_q[slot_q] + SUM_W'(mid_q) - (full_now ? SUM_W'(old_q) : '0);
			mm_q   <= SQR_W'(mid_q) * SQR_W'(mid_q);
			oo_q   <= full_now ? SQR_W'(old_q) * SQR_W'(old_q) : '0;
		end
		if (state_q == ST_SQUARE) begin
			nsq_q <= sq_q[slot_q] + SQ_W'(mm_q) - SQ_W'(oo_q);
		end
	end

	// per-slot state writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SYMBOL_SLOTS; i++) begin
				sum_q[i]  <= '0;
				sq_q[i]   <= '0;
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
				pos_q[i]  <= '0;
			end
		end else begin
			if (state_q == ST_READ) begin
				if (op_q == OP_FILL) begin
					pos_q[slot_q] <= pos_new;
				end else begin
					head_q[slot_q] <= (head_q[slot_q] == HEAD_W'(WINDOW_LENGTH - 1))
						? '0 : head_q[slot_q] + HEAD_W'(1);
					if (!full_now) begin
						cnt_q[slot_q] <= cnt_q[slot_q] + CNT_W'(1);
					end
				end
			end
			if (state_q == ST_SQUARE) begin
				sum_q[slot_q] <= nsum_q;
				sq_q[slot_q]  <= sq_q[slot_q] + SQ_W'(mm_q) - SQ_W'(oo_q);
			end
		end
	end

	// ---------------- variance and deviation ----------------
	assign wm = SUM_W'(mid_q) * SUM_W'(WINDOW_LENGTH);

	always_ff @(posedge clk) begin
		if (state_q == ST_VARIANCE) begin
			// W*sum_sq - sum^2, never negative
			var_q   <= VAR_W'(nsq_q) * VAR_W'(WINDOW_LENGTH)
				- VAR_W'(nsum_q) * VAR_W'(nsum_q);
			above_q <= wm > nsum_q;
			dv_q    <= (wm > nsum_q) ? wm - nsum_q : nsum_q - wm;
		end
		if (state_q == ST_PRODUCT) begin
			d2_q  <= VAR_W'(dv_q) * VAR_W'(dv_q);
			thr_q <= THR_W'(var_q) * THR_W'((pos_cur == '0) ? entry_q : exit_q);
		end
	end

	// ---------------- compare and result ----------------
	always_comb begin
		d4 = {d2_q, 2'b00};
		if (pos_cur == '0) begin
			emit = THR_W'(d4) >= thr_q;
			sell = above_q;
		end else begin
			emit = THR_W'(d4) <= thr_q;
			sell = !pos_cur[POS_W-1];
		end
		emit = emit && eval_q && (var_q != '0) && (op_q == OP_TICK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			order_valid <= emit;
			order_side  <= emit && sell;
			order_price <= !emit ? '0 : (sell ? bid_q : ask_q);
			order_slot  <= emit ? slot_q : '0;
		end
	end

	// ---------------- checks ----------------
	a_accept_starts_read : assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_READ)
		else $error("accepted word did not start a read");

	a_result_from_done : assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_DONE)
		else $error("result appeared outside the final state");

	a_eval_full_window : assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && eval_q && op_q == OP_TICK)
		|-> cnt_q[slot_q] == CNT_W'(WINDOW_LENGTH))
		else $error("evaluation on a window that is not full");

	// slot_q is only meaningful once a word has been taken
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> cnt_q[slot_q] <= CNT_W'(WINDOW_LENGTH))
		else $error("fill count beyond window length");

	a_pos_bound : assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> pos_q[slot_q] != -POS_W'(POS_LIMIT + 1))
		else $error("position outside saturation bounds");

endmodule

`default_nettype wire

FILE: tb/sv/tb_rolling_zscore_signal.sv
// Testbench for rolling_zscore_signal: a directed table, then random ticks and fills per slot.
// It checks every order word against a built-in predictor, or a typed row's own expectation.
// Depends on rzs_pkg and the rolling_zscore_signal RTL only.
module tb_rolling_zscore_signal;
	timeunit 1ns;
	timeprecision 1ps;

	import rzs_pkg::*;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;
	localparam int   BASE_WORDS = 650;
	localparam int   PHASE_WORDS = 130;

	typedef struct packed {
		logic                  ov;
		logic                  side;
		logic [PRICE_BITS-1:0] price;
		logic [SLOT_W-1:0]     slot;
	} order_t;

	localparam order_t NO_ORDER = '0;

	typedef struct packed {
		logic                  op;
		logic [SLOT_W-1:0]     slot;
		logic [PRICE_BITS-1:0] bid;
		logic [PRICE_BITS-1:0] ask;
		logic                  side;
		logic [QTY_W-1:0]      qty;
		logic                  typed;
		order_t                want;
	} row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  operation = OP_TICK;
	logic [SLOT_W-1:0]     symbol_slot = '0;
	logic [PRICE_BITS-1:0] bid_price = '0;
	logic [PRICE_BITS-1:0] ask_price = '0;
	logic                  fill_side = SIDE_BUY;
	logic [QTY_W-1:0]      fill_quantity = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  order_valid;
	logic                  order_side;
	logic [PRICE_BITS-1:0] order_price;
	logic [SLOT_W-1:0]     order_slot;
	logic                  cfg_write = 1'b0;
	logic                  cfg_index = REG_ENTRY;
	logic [RATIO_W-1:0]    cfg_data = '0;

	// typed expectation travelling with the word on the input channel
	logic   row_typed = 1'b0;
	order_t row_want = NO_ORDER;

	int send_gap_pct = 25;
	int stall_pct = 61;

	// predictor state
	logic [MID_W-1:0]   mid_hist [SYMBOL_SLOTS][WINDOW_LENGTH];
	logic [SUM_W-1:0]   run_sum [SYMBOL_SLOTS];
	logic [SQ_W-1:0]    run_sq [SYMBOL_SLOTS];
	int                 fill_n [SYMBOL_SLOTS];
	int                 head [SYMBOL_SLOTS];
	int                 pos_held [SYMBOL_SLOTS];
	logic [RATIO_W-1:0] entry_q = ENTRY_RESET;
	logic [RATIO_W-1:0] exit_q = EXIT_RESET;

	order_t pending_orders [$];
	int     bad_words = 0;
	int     orders_seen = 0;
	int     fill_words = 0;
	int     flat_windows = 0;
	int     settings_used = 1;

	row_t script [19] = '{
		'{OP_FILL, 2'd0, 24'h000000, 24'h000000, SIDE_BUY,  8'd255, 1'b1, NO_ORDER},
		'{OP_FILL, 2'd0, 24'h000000, 24'h000000, SIDE_BUY,  8'd1,   1'b1, NO_ORDER},
		'{OP_FILL, 2'd0, 24'h000000, 24'h000000, SIDE_SELL, 8'd255, 1'b1, NO_ORDER},
		'{OP_FILL, 2'd0, 24'h000000, 24'h000000, SIDE_SELL, 8'd0,   1'b1, NO_ORDER},
		'{OP_FILL, 2'd0, 24'h000000, 24'h000000, SIDE_BUY,  8'd127, 1'b1, NO_ORDER},
		'{OP_FILL, 2'd1, 24'hFFFFFF, 24'hFFFFFF, SIDE_SELL, 8'd128, 1'b1, NO_ORDER},
		'{OP_FILL, 2'd1, 24'h000000, 24'h000000, SIDE_BUY,  8'hAA,  1'b1, NO_ORDER},
		'{OP_FILL, 2'd2, 24'h000000, 24'h000000, SIDE_BUY,  8'h55,  1'b1, NO_ORDER},
		'{OP_FILL, 2'd2, 24'h000000, 24'h000000, SIDE_SELL, 8'h55,  1'b1, NO_ORDER},
		'{OP_FILL, 2'd3, 24'h000000, 24'h000000, SIDE_SELL, 8'd1,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd0, 24'h000000, 24'h000000, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd0, 24'hFFFFFF, 24'hFFFFFF, SIDE_SELL, 8'hFF,  1'b1, NO_ORDER},
		'{OP_TICK, 2'd1, 24'h000000, 24'hFFFFFF, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd2, 24'hFFFFFF, 24'h000000, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd3, 24'hAAAAAA, 24'h555555, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd3, 24'h555555, 24'hAAAAAA, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd2, 24'h123456, 24'h654321, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_TICK, 2'd1, 24'h800000, 24'h7FFFFF, SIDE_BUY,  8'd0,   1'b1, NO_ORDER},
		'{OP_FILL, 2'd3, 24'h000000, 24'h000000, SIDE_BUY,  8'd2,   1'b1, NO_ORDER}
	};

	rolling_zscore_signal dut (.*);

	always #6 clk = ~clk;

	always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

	// One word through the signal: updates the slot state, returns the order word.
	function automatic order_t next_order(input logic op, input logic [SLOT_W-1:0] s,
			input logic [PRICE_BITS-1:0] bid, input logic [PRICE_BITS-1:0] ask,
			input logic side, input logic [QTY_W-1:0] qty);
		order_t         o;
		int             p;
		logic [MID_W-1:0] m;
		logic [MID_W-1:0] prev;
		logic [127:0]   sum_w;
		logic [127:0]   var_w;
		logic [127:0]   wm;
		logic [127:0]   dv;
		logic [127:0]   dev4;
		logic           above;
		logic           fire;
		logic           sell;
		o = NO_ORDER;
		fire = 1'b0;
		sell = 1'b0;
		if (op == OP_FILL) begin
			fill_words++;
			p = (side == SIDE_SELL) ? pos_held[s] - int'(qty) : pos_held[s] + int'(qty);
			if (p > POS_LIMIT)
				p = POS_LIMIT;
			if (p < -POS_LIMIT)
				p = -POS_LIMIT;
			pos_held[s] = p;
			return o;
		end
		m = MID_W'(bid) + MID_W'(ask);
		prev = mid_hist[s][head[s]];
		mid_hist[s][head[s]] = m;
		head[s] = (head[s] == WINDOW_LENGTH - 1) ? 0 : head[s] + 1;
		if (fill_n[s] < WINDOW_LENGTH) begin
			fill_n[s]++;
			run_sum[s] = run_sum[s] + SUM_W'(m);
			run_sq[s] = run_sq[s] + SQ_W'(m) * SQ_W'(m);
			if (fill_n[s] < WINDOW_LENGTH)
				return o;
		end else begin
			run_sum[s] = run_sum[s] + SUM_W'(m) - SUM_W'(prev);
			run_sq[s] = run_sq[s] + SQ_W'(m) * SQ_W'(m) - SQ_W'(prev) * SQ_W'(prev);
		end
		// everything scaled by the window length squared, so it stays exact
		sum_w = 128'(run_sum[s]);
		var_w = 128'(run_sq[s]) * 128'(WINDOW_LENGTH) - sum_w * sum_w;
		if (var_w == '0) begin
			flat_windows++;
			return o;
		end
		wm = 128'(m) * 128'(WINDOW_LENGTH);
		above = wm > sum_w;
		dv = above ? wm - sum_w : sum_w - wm;
		dev4 = dv * dv * 128'd4;
		if (pos_held[s] == 0) begin
			if (dev4 >= var_w * 128'(entry_q)) begin
				fire = 1'b1;
				sell = above;
			end
		end else if (dev4 <= var_w * 128'(exit_q)) begin
			fire = 1'b1;
			sell = pos_held[s] > 0;
		end
		if (fire)
			o = {1'b1, sell, sell ? bid : ask, s};
		return o;
	endfunction

	always @(posedge clk) begin
		order_t got;
		order_t want;
		if (arst_n) begin
			if (cfg_write) begin
				case (cfg_index)
					REG_ENTRY: entry_q = cfg_data;
					REG_EXIT:  exit_q = cfg_data;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = {order_valid, order_side, order_price, order_slot};
				if (got.ov)
					orders_seen++;
				if (pending_orders.size() == 0) begin
					bad_words++;
					if (bad_words <= 10)
						$display("%0t: order word with none expected:", $realtime,
							" valid %0b side %0b price %h slot %0d",
							got.ov, got.side, got.price, got.slot);
				end else begin
					want = pending_orders.pop_front();
					if (got !== want) begin
						bad_words++;
						if (bad_words <= 10) begin
							$display("%0t: order mismatch: expected valid %0b side %0b",
								$realtime, want.ov, want.side,
								" price %h slot %0d", want.price, want.slot);
							$display("    got valid %0b side %0b price %h slot %0d",
								got.ov, got.side, got.price, got.slot);
						end
					end
				end
			end
			if (in_valid && !in_stall) begin
				want = next_order(operation, symbol_slot, bid_price, ask_price,
					fill_side, fill_quantity);
				if (row_typed)
					want = row_want;
				pending_orders.push_back(want);
			end
		end
	end

	task automatic send_word(input row_t r);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		operation <= r.op;
		symbol_slot <= r.slot;
		bid_price <= r.bid;
		ask_price <= r.ask;
		fill_side <= r.side;
		fill_quantity <= r.qty;
		row_typed <= r.typed;
		row_want <= r.want;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// drain: every order word back, then let the sequencer go idle
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_orders.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		row_t r;
		int   base [SYMBOL_SLOTS];
		int   flat_left [SYMBOL_SLOTS];
		int   off;
		int   k;
		logic [RATIO_W-1:0] new_entry;
		logic [RATIO_W-1:0] new_exit;
		for (int i = 0; i < SYMBOL_SLOTS; i++) begin
			run_sum[i] = '0;
			run_sq[i] = '0;
			fill_n[i] = 0;
			head[i] = 0;
			pos_held[i] = 0;
			base[i] = int'($urandom_range(2000, 16_774_000));
			flat_left[i] = 0;
		end
		flat_left[3] = 80;	// long enough to hold a constant window
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			send_word(script[i]);

		for (int n = 0; n < BASE_WORDS; n++) begin
			if (n > 0 && n % PHASE_WORDS == 0 && n <= 4 * PHASE_WORDS) begin
				k = n / PHASE_WORDS;
				case (k)
					1: begin new_entry = 8'd0;   new_exit = 8'd255; end
					2: begin new_entry = 8'd255; new_exit = 8'd0;   end
					3: begin new_entry = 8'd12;  new_exit = 8'd3;   end
					default: begin
						new_entry = RATIO_W'($urandom_range(0, 255));
						new_exit = RATIO_W'($urandom_range(0, 255));
					end
				endcase
				settle();
				cfg_write <= 1'b1;
				cfg_index <= REG_ENTRY;
				cfg_data <= new_entry;
				@(posedge clk);
				cfg_index <= REG_EXIT;
				cfg_data <= new_exit;
				@(posedge clk);
				cfg_write <= 1'b0;
				@(posedge clk);
				settings_used++;
			end
			if (n < BASE_WORDS / 3) begin
				send_gap_pct = 25;
				stall_pct = 61;
			end else if (n < 2 * BASE_WORDS / 3) begin
				send_gap_pct = 61;
				stall_pct = 25;
			end else begin
				send_gap_pct = 0;
				stall_pct = 0;
			end

			r = '0;
			r.slot = SLOT_W'($urandom_range(0, SYMBOL_SLOTS - 1));
			r.side = $urandom_range(0, 1) ? SIDE_SELL : SIDE_BUY;
			if ($urandom_range(0, 39) == 0) begin
				// noise word, anything the fields allow
				r.op = $urandom_range(0, 1) ? OP_FILL : OP_TICK;
				r.bid = PRICE_BITS'($urandom_range(0, 24'hFFFFFF));
				r.ask = PRICE_BITS'($urandom_range(0, 24'hFFFFFF));
				r.qty = QTY_W'($urandom_range(0, 255));
			end else if ($urandom_range(0, 4) == 0) begin
				r.op = OP_FILL;
				r.qty = ($urandom_range(0, 9) == 0) ? QTY_W'($urandom_range(0, 255))
					: QTY_W'($urandom_range(1, 3));
			end else begin
				r.op = OP_TICK;
				if (flat_left[r.slot] == 0 && $urandom_range(0, 399) == 0)
					flat_left[r.slot] = 70;
				if (flat_left[r.slot] > 0) begin
					flat_left[r.slot]--;
					r.bid = PRICE_BITS'(base[r.slot]);
					r.ask = PRICE_BITS'(base[r.slot] + 2);
				end else begin
					base[r.slot] += int'($urandom_range(0, 2)) - 1;
					off = int'($urandom_range(0, 16)) - 8;
					if ($urandom_range(0, 11) == 0)
						off += ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(60, 400));
					r.bid = PRICE_BITS'(base[r.slot] + off);
					r.ask = PRICE_BITS'(base[r.slot] + off + int'($urandom_range(1, 4)));
				end
			end
			send_word(r);
		end

		settle();
		$display("covered %0d fills, %0d orders and %0d zero-variance ticks",
			fill_words, orders_seen, flat_windows);
		$display("across %0d threshold settings and three idling patterns", settings_used);
		if (bad_words == 0 && pending_orders.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/rzs_pkg.sv
hdl/rolling_zscore_signal.sv
tb/sv/tb_rolling_zscore_signal.sv
